/* hdl/pids_pkg.sv */
// ----------------------------------------------------------------------------
// pids_pkg: shared constants and types
// Register indexes, reset values and fault codes of the PWM diagnostic block.
// ----------------------------------------------------------------------------
package pids_pkg;

  localparam int unsigned OutPeriodTicks = 100;
  localparam int unsigned TimerBits      = 16;
  localparam int unsigned NumFaults      = 5;
  localparam int unsigned QueueDepth     = 2;

  localparam logic [2:0] RegClockHz  = 3'd0;
  localparam logic [2:0] RegConfirm  = 3'd1;
  localparam logic [2:0] RegHold     = 3'd2;
  localparam logic [2:0] RegNomLow   = 3'd3;
  localparam logic [2:0] RegNomHigh  = 3'd4;

  localparam logic [25:0] ClockHzReset  = 26'd625000;
  localparam logic [15:0] ConfirmReset  = 16'd400;
  localparam logic [15:0] HoldReset     = 16'd5000;
  localparam logic [9:0]  NomLowReset   = 10'd100;
  localparam logic [9:0]  NomHighReset  = 10'd250;

  localparam logic [6:0] CodeOk = 7'd11;
  localparam logic [6:0] CodeDutyLow  = 7'd65;
  localparam logic [6:0] CodeDutyHigh = 7'd70;
  localparam logic [6:0] CodeFreqLow  = 7'd75;
  localparam logic [6:0] CodeFreqMid  = 7'd80;
  localparam logic [6:0] CodeFreqHigh = 7'd85;

  // one classified request handed from front to back
  typedef struct packed {
    logic        is_cap;  // capture with non-zero period
    logic        is_tick;
    logic [6:0]  duty;
    logic [15:0] freq;
  } work_t;

  function automatic logic [6:0] fault_code(input logic [2:0] idx);
    logic [6:0] c;
    case (idx)
      3'd0: c = CodeDutyLow;
      3'd1: c = CodeDutyHigh;
      3'd2: c = CodeFreqLow;
      3'd3: c = CodeFreqMid;
      default: c = CodeFreqHigh;
    endcase
    return c;
  endfunction

endpackage

/* hdl/pids_if.sv */
// ----------------------------------------------------------------------------
// pids_if: valid/ready channels
// Input, result and configuration write channels.
// ----------------------------------------------------------------------------
interface pids_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] high_ticks;
  logic [15:0] per_ticks;
  modport source (output valid, cmd, high_ticks, per_ticks, input ready);
  modport sink   (input valid, cmd, high_ticks, per_ticks, output ready);
endinterface

interface pids_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  status_code;
  logic        pin_level;
  logic [6:0]  duty_percent;
  logic [15:0] freq_hz;
  modport source (output valid, status_code, pin_level, duty_percent, freq_hz,
                  input ready);
  modport sink   (input valid, status_code, pin_level, duty_percent, freq_hz,
                  output ready);
endinterface

interface pids_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/pids_front.sv */
// ----------------------------------------------------------------------------
// pids_front: capture measurement
// Accepts requests; for a capture with a non-zero period it runs a restoring divider for duty and frequency.
// ----------------------------------------------------------------------------
module pids_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [25:0]       clock_hz_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cmd_i,
  input  logic [15:0]       high_i,
  input  logic [15:0]       period_i,
  output logic              wr_valid_o,
  input  logic              wr_ready_i,
  output pids_pkg::work_t   wr_data_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDuty = 2'd1;
  localparam logic [1:0] StFreq = 2'd2;
  localparam logic [1:0] StPush = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [25:0] num_q, num_d;     // dividend shifting out, quotient shifting in
  logic [15:0] rem_q, rem_d;
  logic [15:0] div_q, div_d;
  pids_pkg::work_t w_q, w_d;

  logic [16:0] trial;
  logic [16:0] sub;
  logic        ge;
  logic [15:0] hclamp;
  logic [22:0] dprod;

  assign in_ready_o = (state_q == StIdle);
  assign wr_valid_o = (state_q == StPush);
  assign wr_data_o  = w_q;
  assign hclamp     = (high_i > period_i) ? period_i : high_i;
  // 100 * (period - high) fits in 23 bits
  assign dprod      = 23'(period_i - hclamp) * 23'd100;

  assign trial = {rem_q, num_q[25]};
  assign ge    = trial >= {1'b0, div_q};
  assign sub   = trial - {1'b0, div_q};

  // divider sequencer: 23 steps for duty, 26 for frequency
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    rem_d   = rem_q;
    div_d   = div_q;
    w_d     = w_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          w_d.is_tick = ~cmd_i;
          w_d.is_cap  = cmd_i && (period_i != 16'd0);
          div_d = period_i;
          rem_d = '0;
          num_d = {dprod, 3'd0};
          cnt_d = 5'd0;
          state_d = (cmd_i && period_i != 16'd0) ? StDuty : StPush;
        end
      end
      StDuty, StFreq: begin
        rem_d = ge ? sub[15:0] : trial[15:0];
        num_d = {num_q[24:0], ge};
        cnt_d = cnt_q + 5'd1;
        if (state_q == StDuty && cnt_q == 5'd22) begin
          w_d.duty = {num_q[5:0], ge};
          rem_d = '0;
          num_d = clock_hz_i;
          cnt_d = 5'd0;
          state_d = StFreq;
        end else if (state_q == StFreq && cnt_q == 5'd25) begin
          w_d.freq = (num_q[24:15] != 10'd0) ? 16'hFFFF : {num_q[14:0], ge};
          state_d = StPush;
        end
      end
      StPush: if (wr_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
    w_q   <= w_d;
  end

endmodule

/* hdl/pids_queue.sv */
// ----------------------------------------------------------------------------
// pids_queue: small FIFO
// Two-entry queue between measurement front and diagnosis back.
// ----------------------------------------------------------------------------
module pids_queue #(
  parameter int unsigned Depth = pids_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  pids_pkg::work_t wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output pids_pkg::work_t rd_data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  pids_pkg::work_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          push, pop;

  assign wr_ready_o = (cnt_q != (AW+1)'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= nxt(wp_q);
      if (pop)  rp_q <= nxt(rp_q);
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

endmodule

/* hdl/pids_back.sv */
// ----------------------------------------------------------------------------
// pids_back: diagnosis and status PWM
// Timers, fault confirmation and toggle generator; one result per request.
// ----------------------------------------------------------------------------
module pids_back #(
  parameter int unsigned TimerW = pids_pkg::TimerBits
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     confirm_i,
  input  logic [15:0]     hold_i,
  input  logic [9:0]      nom_lo_i,
  input  logic [9:0]      nom_hi_i,
  input  logic            rd_valid_i,
  output logic            rd_ready_o,
  input  pids_pkg::work_t rd_data_i,
  pids_out_if.source      out
);

  localparam int unsigned N = pids_pkg::NumFaults;
  localparam logic [TimerW-1:0] TMax = '1;

  logic [6:0]        duty_q, code_q;
  logic [15:0]       freq_q;
  logic [TimerW-1:0] hold_q, ocnt_q, ctmr_q [N];
  logic [N-1:0]      armed_q;
  logic              phase_q, tog_q, pin_q, ovld_q;

  logic [6:0]        duty_d, code_d;
  logic [15:0]       freq_d;
  logic [TimerW-1:0] hold_d, ocnt_d, ctmr_d [N];
  logic [N-1:0]      armed_d, act;
  logic              phase_d, tog_d, pin_d, ok;
  logic [TimerW-1:0] cload, hload;
  logic signed [11:0] f, d, lo, hi;
  logic [6:0]        lowt;
  logic              take;

  assign rd_ready_o = !ovld_q || out.ready;
  assign take = rd_valid_i && rd_ready_o;

  // saturate 16-bit loads to the timer width
  function automatic logic [TimerW-1:0] sat(input logic [15:0] v);
    if (TimerW >= 16) return TimerW'(v);
    return (v > 16'(TMax)) ? TMax : TimerW'(v);
  endfunction
  assign cload = sat(confirm_i);
  assign hload = sat(hold_i);

  always_comb begin
    duty_d = duty_q; freq_d = freq_q; code_d = code_q; hold_d = hold_q;
    ocnt_d = ocnt_q; armed_d = armed_q; phase_d = phase_q;
    tog_d = tog_q; pin_d = pin_q;
    for (int i = 0; i < N; i++) ctmr_d[i] = ctmr_q[i];
    // measurement update or tick
    if (rd_data_i.is_cap) begin
      duty_d = rd_data_i.duty;
      freq_d = rd_data_i.freq;
    end
    if (rd_data_i.is_tick) begin
      if (ocnt_d != TMax) ocnt_d = ocnt_d + TimerW'(1);
      if (hold_d != '0) hold_d = hold_d - TimerW'(1);
      for (int i = 0; i < N; i++)
        if (ctmr_d[i] != '0) ctmr_d[i] = ctmr_d[i] - TimerW'(1);
    end
    // diagnosis
    f  = {1'b0, (freq_d > 16'd2047) ? 11'h7FF : freq_d[10:0]};
    d  = {5'd0, duty_d};
    lo = {2'd0, nom_lo_i};
    hi = {2'd0, nom_hi_i};
    ok = ((f >= lo - 12'sd1 && f <= lo + 12'sd1) || (f >= hi - 12'sd1 && f <= hi + 12'sd1))
         && d > 12'sd2 && d < 12'sd98;
    act[0] = d < 12'sd3;
    act[1] = d > 12'sd97;
    act[2] = f <= lo - 12'sd2;
    act[3] = f >= lo + 12'sd2 && f <= hi - 12'sd2;
    act[4] = f >= hi + 12'sd2;
    if (hold_d <= TimerW'(1)) begin
      if (ok) begin
        code_d = pids_pkg::CodeOk;
      end else begin
        for (int i = 0; i < N; i++) begin
          if (act[i]) begin
            if (!armed_d[i]) begin
              ctmr_d[i] = cload;
              armed_d[i] = 1'b1;
            end
            if (ctmr_d[i] <= TimerW'(1)) begin
              code_d = pids_pkg::fault_code(3'(i));
              armed_d[i] = 1'b0;
              hold_d = hload;
            end
          end
        end
      end
    end
    // toggle generator
    lowt = 7'(pids_pkg::OutPeriodTicks) - code_d;
    if (!phase_d && ocnt_d >= TimerW'(code_d)) begin
      pin_d = tog_d; tog_d = ~tog_d; ocnt_d = '0; phase_d = 1'b1;
    end
    if (phase_d && ocnt_d >= TimerW'(lowt)) begin
      pin_d = tog_d; tog_d = ~tog_d; ocnt_d = '0; phase_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q <= '0; freq_q <= '0; code_q <= pids_pkg::CodeOk; hold_q <= '0;
      ocnt_q <= '0; armed_q <= '0; phase_q <= 1'b0; tog_q <= 1'b0;
      pin_q <= 1'b0; ovld_q <= 1'b0;
      for (int i = 0; i < N; i++) ctmr_q[i] <= '0;
    end else begin
      if (take) begin
        duty_q <= duty_d; freq_q <= freq_d; code_q <= code_d; hold_q <= hold_d;
        ocnt_q <= ocnt_d; armed_q <= armed_d; phase_q <= phase_d;
        tog_q <= tog_d; pin_q <= pin_d;
        for (int i = 0; i < N; i++) ctmr_q[i] <= ctmr_d[i];
      end
      if (take) ovld_q <= 1'b1;
      else if (out.ready) ovld_q <= 1'b0;
    end
  end

  assign out.valid        = ovld_q;
  assign out.status_code  = code_q;
  assign out.pin_level    = pin_q;
  assign out.duty_percent = duty_q;
  assign out.freq_hz      = freq_q;

  // code is always ok or a fault code
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_q == pids_pkg::CodeOk || code_q == pids_pkg::CodeDutyLow ||
    code_q == pids_pkg::CodeDutyHigh || code_q == pids_pkg::CodeFreqLow ||
    code_q == pids_pkg::CodeFreqMid || code_q == pids_pkg::CodeFreqHigh)
    else $error("bad status code");
  a_duty: assert property (@(posedge clk_i) disable iff (!rst_ni) duty_q <= 7'd100)
    else $error("duty out of range");
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni) take |=> ovld_q)
    else $error("result lost");

endmodule

/* hdl/pwm_input_diagnostic_status_pwm.sv */
// ----------------------------------------------------------------------------
// pwm_input_diagnostic_status_pwm: input PWM diagnosis with status PWM
// Measures a captured PWM, confirms faults and reports a status code.
// ----------------------------------------------------------------------------
// One result per request. A tick, or a capture with a zero period, goes from
// the idle state of the front straight to its push state. A capture with a
// non-zero period first runs the duty and then the frequency division of the
// one-bit-per-cycle restoring divider in the front (23 steps for duty, 26 for
// frequency). The front takes no new request before leaving its push state.
// A two-entry queue decouples measurement from diagnosis; a stalled result
// output backs up through the queue and then holds off the input.
module pwm_input_diagnostic_status_pwm #(
  parameter int unsigned TimerW     = pids_pkg::TimerBits,
  parameter int unsigned QueueDepth = pids_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pids_in_if.sink     in_ch,
  pids_out_if.source  out_ch,
  pids_cfg_if.sink    cfg_ch
);

  logic [25:0] clk_hz_q;
  logic [15:0] confirm_q, hold_q;
  logic [9:0]  lo_q, hi_q;
  logic        wv, wr, rv, rr;
  pids_pkg::work_t wd, rd;

  assign cfg_ch.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q  <= pids_pkg::ClockHzReset;
      confirm_q <= pids_pkg::ConfirmReset;
      hold_q    <= pids_pkg::HoldReset;
      lo_q      <= pids_pkg::NomLowReset;
      hi_q      <= pids_pkg::NomHighReset;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        pids_pkg::RegClockHz: clk_hz_q  <= cfg_ch.data[25:0];
        pids_pkg::RegConfirm: confirm_q <= cfg_ch.data[15:0];
        pids_pkg::RegHold:    hold_q    <= cfg_ch.data[15:0];
        pids_pkg::RegNomLow:  lo_q      <= cfg_ch.data[9:0];
        pids_pkg::RegNomHigh: hi_q      <= cfg_ch.data[9:0];
        default: ;
      endcase
    end
  end

  pids_front u_front (
    .clk_i, .rst_ni, .clock_hz_i(clk_hz_q),
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready), .cmd_i(in_ch.cmd),
    .high_i(in_ch.high_ticks), .period_i(in_ch.per_ticks),
    .wr_valid_o(wv), .wr_ready_i(wr), .wr_data_o(wd)
  );

  pids_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .wr_valid_i(wv), .wr_ready_o(wr), .wr_data_i(wd),
    .rd_valid_o(rv), .rd_ready_i(rr), .rd_data_o(rd)
  );

  pids_back #(.TimerW(TimerW)) u_back (
    .clk_i, .rst_ni, .confirm_i(confirm_q), .hold_i(hold_q),
    .nom_lo_i(lo_q), .nom_hi_i(hi_q),
    .rd_valid_i(rv), .rd_ready_o(rr), .rd_data_i(rd), .out(out_ch)
  );

endmodule
